[hw/rtl/irqt_pkg.sv]
// ----------------------------------------------------------------------------
// irqt_pkg: shared types and constants for the region quality tally
// Class and level codes, configuration register indexes, queue entry type.
// ----------------------------------------------------------------------------
package irqt_pkg;

	localparam int MAX_REGIONS_DEF = 256;
	localparam int QUEUE_DEPTH     = 4;
	localparam int TALLY_W         = 9;
	localparam int CLASS_W         = 3;
	localparam int LEVEL_W         = 2;
	localparam int NUM_CLASSES     = 5;
	localparam int CFG_INDEX_W     = 3;
	localparam int CFG_DATA_W      = 64;

	typedef enum logic [CLASS_W-1:0] {
		CLS_NORMAL    = 3'd0,
		CLS_DARK      = 3'd1,
		CLS_BLOCKAGE  = 3'd2,
		CLS_LOWVIS    = 3'd3,
		CLS_BACKLIGHT = 3'd4
	} cls_t;

	typedef enum logic [LEVEL_W-1:0] {
		LVL_OK   = 2'd0,
		LVL_WARN = 2'd1,
		LVL_ERR  = 2'd2
	} level_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SHADOW_INT    = 3'd0,
		REG_HIGHLIGHT_INT = 3'd1,
		REG_BLOCK_FRAC    = 3'd2,
		REG_BLOCK_SPEC    = 3'd3,
		REG_LOWVIS_SPEC   = 3'd4,
		REG_WARN_LIMITS   = 3'd5,
		REG_ERROR_LIMITS  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic        [7:0]  shadow_int;
		logic        [7:0]  highlight_int;
		logic        [15:0] block_frac;
		logic signed [15:0] block_spec;
		logic signed [15:0] lowvis_spec;
	} class_cfg_t;

	typedef struct packed {
		cls_t cls;
		logic last;
	} queue_entry_t;

endpackage

[hw/rtl/image_region_quality_tally.sv]
// ----------------------------------------------------------------------------
// image_region_quality_tally: per-region class and per-frame quality tally
// Feed one region's features per beat on the input channel (in_valid /
// in_stall); each beat gives one result beat on the output channel
// (out_valid / out_stall), in order. The result carries the region class;
// on a beat with last_region set it also carries the five frame counts, the
// four category levels and the overall level, and the counts then restart.
// A front classifier pushes into a four-entry queue; the tally stage pops
// it into the output register. Throughput: one region per cycle while
// out_stall stays low, set by the single tally update per cycle. When
// out_stall holds, the result stays put and the queue fills; in_stall rises
// once the queue is full. Configuration writes (cfg_valid, always ready)
// take effect at once; the user must make them while no region is in
// flight, as the block itself does not enforce it. Reset clears the
// tallies, empties the queue and loads the default limits.
// ----------------------------------------------------------------------------
module image_region_quality_tally #(
	parameter int MAX_REGIONS = irqt_pkg::MAX_REGIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         mean_intensity,
	input  logic [15:0]                        dark_fraction,
	input  logic signed [15:0]                 spectrum_mean,
	input  logic                               last_region,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [irqt_pkg::CLASS_W-1:0]       region_class,
	output logic                               frame_done,
	output logic [irqt_pkg::TALLY_W-1:0]       normal_count,
	output logic [irqt_pkg::TALLY_W-1:0]       dark_count,
	output logic [irqt_pkg::TALLY_W-1:0]       blockage_count,
	output logic [irqt_pkg::TALLY_W-1:0]       low_vis_count,
	output logic [irqt_pkg::TALLY_W-1:0]       backlight_count,
	output logic [irqt_pkg::LEVEL_W-1:0]       blockage_level,
	output logic [irqt_pkg::LEVEL_W-1:0]       highlight_level,
	output logic [irqt_pkg::LEVEL_W-1:0]       shadow_level,
	output logic [irqt_pkg::LEVEL_W-1:0]       low_vis_level,
	output logic [irqt_pkg::LEVEL_W-1:0]       overall_level,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [irqt_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [irqt_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import irqt_pkg::*;

	class_cfg_t              class_cfg_q;
	logic [CFG_DATA_W-1:0]   warn_limits_q;
	logic [CFG_DATA_W-1:0]   error_limits_q;
	logic                    push, pop, q_full, q_not_empty;
	queue_entry_t            push_entry, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_cfg_q.shadow_int    <= 8'd0;
			class_cfg_q.highlight_int <= 8'd255;
			class_cfg_q.block_frac    <= 16'hFFFF;
			class_cfg_q.block_spec    <= 16'sh8000;
			class_cfg_q.lowvis_spec   <= 16'sh8000;
			warn_limits_q             <= '1;
			error_limits_q            <= '1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHADOW_INT:    class_cfg_q.shadow_int    <= cfg_data[7:0];
				REG_HIGHLIGHT_INT: class_cfg_q.highlight_int <= cfg_data[7:0];
				REG_BLOCK_FRAC:    class_cfg_q.block_frac    <= cfg_data[15:0];
				REG_BLOCK_SPEC:    class_cfg_q.block_spec    <= cfg_data[15:0];
				REG_LOWVIS_SPEC:   class_cfg_q.lowvis_spec   <= cfg_data[15:0];
				REG_WARN_LIMITS:   warn_limits_q             <= cfg_data;
				REG_ERROR_LIMITS:  error_limits_q            <= cfg_data;
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	irqt_front u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mean_intensity (mean_intensity),
		.dark_fraction  (dark_fraction),
		.spectrum_mean  (spectrum_mean),
		.last_region    (last_region),
		.cfg            (class_cfg_q),
		.queue_full     (q_full),
		.push           (push),
		.push_entry     (push_entry)
	);

	irqt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	irqt_back #(
		.MAX_REGIONS (MAX_REGIONS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_not_empty     (q_not_empty),
		.q_head          (q_head),
		.pop             (pop),
		.warn_limits     (warn_limits_q),
		.error_limits    (error_limits_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.region_class    (region_class),
		.frame_done      (frame_done),
		.normal_count    (normal_count),
		.dark_count      (dark_count),
		.blockage_count  (blockage_count),
		.low_vis_count   (low_vis_count),
		.backlight_count (backlight_count),
		.blockage_level  (blockage_level),
		.highlight_level (highlight_level),
		.shadow_level    (shadow_level),
		.low_vis_level   (low_vis_level),
		.overall_level   (overall_level)
	);

endmodule

[hw/rtl/irqt_front.sv]
// ----------------------------------------------------------------------------
// irqt_front: region classifier
// Runs the priority compare chain on one region and pushes its class.
// ----------------------------------------------------------------------------
module irqt_front (
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               mean_intensity,
	input  logic [15:0]              dark_fraction,
	input  logic signed [15:0]       spectrum_mean,
	input  logic                     last_region,
	input  irqt_pkg::class_cfg_t     cfg,
	input  logic                     queue_full,
	output logic                     push,
	output irqt_pkg::queue_entry_t   push_entry
);
	import irqt_pkg::*;

	cls_t cls;

	always_comb begin
		if (mean_intensity < cfg.shadow_int) begin
			cls = CLS_DARK;
		end else if (dark_fraction > cfg.block_frac && spectrum_mean < cfg.block_spec) begin
			cls = CLS_BLOCKAGE;
		end else if (spectrum_mean < cfg.lowvis_spec && mean_intensity < cfg.highlight_int) begin
			cls = CLS_LOWVIS;
		end else if (mean_intensity > cfg.highlight_int) begin
			cls = CLS_BACKLIGHT;
		end else begin
			cls = CLS_NORMAL;
		end
	end

	assign in_stall        = queue_full;
	assign push            = in_valid && !queue_full;
	assign push_entry.cls  = cls;
	assign push_entry.last = last_region;

endmodule

[hw/rtl/irqt_queue.sv]
// ----------------------------------------------------------------------------
// irqt_queue: short class queue
// Decouples the classifier from the tally stage.
// ----------------------------------------------------------------------------
module irqt_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  irqt_pkg::queue_entry_t  push_entry,
	output logic                    full,
	input  logic                    pop,
	output logic                    not_empty,
	output irqt_pkg::queue_entry_t  head
);
	import irqt_pkg::*;

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	queue_entry_t        slot_q [QUEUE_DEPTH];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;

	assign full      = (count_q == CntW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/irqt_back.sv]
// ----------------------------------------------------------------------------
// irqt_back: frame tally and result register
// Counts classes per frame and grades the counts on the last region.
// ----------------------------------------------------------------------------
module irqt_back #(
	parameter int MAX_REGIONS = irqt_pkg::MAX_REGIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_not_empty,
	input  irqt_pkg::queue_entry_t             q_head,
	output logic                               pop,
	input  logic [irqt_pkg::CFG_DATA_W-1:0]    warn_limits,
	input  logic [irqt_pkg::CFG_DATA_W-1:0]    error_limits,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [irqt_pkg::CLASS_W-1:0]       region_class,
	output logic                               frame_done,
	output logic [irqt_pkg::TALLY_W-1:0]       normal_count,
	output logic [irqt_pkg::TALLY_W-1:0]       dark_count,
	output logic [irqt_pkg::TALLY_W-1:0]       blockage_count,
	output logic [irqt_pkg::TALLY_W-1:0]       low_vis_count,
	output logic [irqt_pkg::TALLY_W-1:0]       backlight_count,
	output logic [irqt_pkg::LEVEL_W-1:0]       blockage_level,
	output logic [irqt_pkg::LEVEL_W-1:0]       highlight_level,
	output logic [irqt_pkg::LEVEL_W-1:0]       shadow_level,
	output logic [irqt_pkg::LEVEL_W-1:0]       low_vis_level,
	output logic [irqt_pkg::LEVEL_W-1:0]       overall_level
);
	import irqt_pkg::*;

	localparam int TallyFieldMax = (1 << TALLY_W) - 1;
	localparam int TallyCapInt   = (MAX_REGIONS < TallyFieldMax) ? MAX_REGIONS : TallyFieldMax;
	localparam logic [TALLY_W-1:0] TallyCap = TALLY_W'(TallyCapInt);

	function automatic level_t grade(input logic [TALLY_W-1:0] cnt,
	                                 input logic [15:0] warn_lim,
	                                 input logic [15:0] err_lim);
		logic [15:0] cnt_x;
		begin
			cnt_x = 16'(cnt);
			if (cnt_x > err_lim) begin
				grade = LVL_ERR;
			end else if (cnt_x > warn_lim) begin
				grade = LVL_WARN;
			end else begin
				grade = LVL_OK;
			end
		end
	endfunction

	logic [TALLY_W-1:0] tally_q   [NUM_CLASSES];
	logic [TALLY_W-1:0] tally_nxt [NUM_CLASSES];
	level_t             lvl_block, lvl_high, lvl_shadow, lvl_lowvis, lvl_max;
	logic               out_valid_q;

	assign out_valid = out_valid_q;
	assign pop       = q_not_empty && (!out_valid_q || !out_stall);

	always_comb begin
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (q_head.cls == CLASS_W'(i) && tally_q[i] < TallyCap) begin
				tally_nxt[i] = tally_q[i] + 1'b1;
			end else begin
				tally_nxt[i] = tally_q[i];
			end
		end
	end

	always_comb begin
		lvl_block  = grade(tally_nxt[CLS_BLOCKAGE],  warn_limits[15:0],  error_limits[15:0]);
		lvl_high   = grade(tally_nxt[CLS_BACKLIGHT], warn_limits[31:16], error_limits[31:16]);
		lvl_shadow = grade(tally_nxt[CLS_DARK],      warn_limits[47:32], error_limits[47:32]);
		lvl_lowvis = grade(tally_nxt[CLS_LOWVIS],    warn_limits[63:48], error_limits[63:48]);
		lvl_max    = lvl_block;
		if (lvl_high > lvl_max) begin
			lvl_max = lvl_high;
		end
		if (lvl_shadow > lvl_max) begin
			lvl_max = lvl_shadow;
		end
		if (lvl_lowvis > lvl_max) begin
			lvl_max = lvl_lowvis;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				tally_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				for (int i = 0; i < NUM_CLASSES; i++) begin
					// clear the frame after its last region
					tally_q[i] <= q_head.last ? '0 : tally_nxt[i];
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			region_class <= q_head.cls;
			frame_done   <= q_head.last;
			if (q_head.last) begin
				normal_count    <= tally_nxt[CLS_NORMAL];
				dark_count      <= tally_nxt[CLS_DARK];
				blockage_count  <= tally_nxt[CLS_BLOCKAGE];
				low_vis_count   <= tally_nxt[CLS_LOWVIS];
				backlight_count <= tally_nxt[CLS_BACKLIGHT];
				blockage_level  <= lvl_block;
				highlight_level <= lvl_high;
				shadow_level    <= lvl_shadow;
				low_vis_level   <= lvl_lowvis;
				overall_level   <= lvl_max;
			end else begin
				normal_count    <= '0;
				dark_count      <= '0;
				blockage_count  <= '0;
				low_vis_count   <= '0;
				backlight_count <= '0;
				blockage_level  <= LVL_OK;
				highlight_level <= LVL_OK;
				shadow_level    <= LVL_OK;
				low_vis_level   <= LVL_OK;
				overall_level   <= LVL_OK;
			end
		end
	end

endmodule

[tb/sv/irqt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irqt_checker: result predictor and scoreboard for the region quality tally
// Watches the region, result and configuration channels. Every region beat
// taken is classed and tallied against a private copy of the limits, and the
// expected result is queued. Each result beat is compared field by field
// with the oldest expected result. Mismatches and the number of results
// still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module irqt_checker #(
	parameter int MAX_REGIONS = irqt_pkg::MAX_REGIONS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [7:0]                       mean_intensity,
	input  logic [15:0]                      dark_fraction,
	input  logic signed [15:0]               spectrum_mean,
	input  logic                             last_region,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [irqt_pkg::CLASS_W-1:0]     region_class,
	input  logic                             frame_done,
	input  logic [irqt_pkg::TALLY_W-1:0]     normal_count,
	input  logic [irqt_pkg::TALLY_W-1:0]     dark_count,
	input  logic [irqt_pkg::TALLY_W-1:0]     blockage_count,
	input  logic [irqt_pkg::TALLY_W-1:0]     low_vis_count,
	input  logic [irqt_pkg::TALLY_W-1:0]     backlight_count,
	input  logic [irqt_pkg::LEVEL_W-1:0]     blockage_level,
	input  logic [irqt_pkg::LEVEL_W-1:0]     highlight_level,
	input  logic [irqt_pkg::LEVEL_W-1:0]     shadow_level,
	input  logic [irqt_pkg::LEVEL_W-1:0]     low_vis_level,
	input  logic [irqt_pkg::LEVEL_W-1:0]     overall_level,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [irqt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [irqt_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               mismatches,
	output int                               pending
);
	import irqt_pkg::*;

	localparam int TALLY_CAP = (MAX_REGIONS < 511) ? MAX_REGIONS : 511;

	typedef struct packed {
		cls_t               cls;
		logic               done;
		logic [TALLY_W-1:0] normal_n;
		logic [TALLY_W-1:0] dark_n;
		logic [TALLY_W-1:0] blockage_n;
		logic [TALLY_W-1:0] low_vis_n;
		logic [TALLY_W-1:0] backlight_n;
		level_t             blockage_lvl;
		level_t             highlight_lvl;
		level_t             shadow_lvl;
		level_t             low_vis_lvl;
		level_t             overall_lvl;
	} region_result_t;

	class_cfg_t         class_limits;
	logic [63:0]        warn_limits;
	logic [63:0]        error_limits;
	logic [TALLY_W-1:0] tallies [NUM_CLASSES];
	region_result_t     expected_results [$];

	function automatic level_t grade(logic [TALLY_W-1:0] count, logic [15:0] err_lim,
			logic [15:0] warn_lim);
		if (count > err_lim)
			return LVL_ERR;
		if (count > warn_lim)
			return LVL_WARN;
		return LVL_OK;
	endfunction

	function automatic level_t worse(level_t a, level_t b);
		return (b > a) ? b : a;
	endfunction

	// Class one region, bump its tally and close the frame on the last region.
	function automatic region_result_t classify_region(logic [7:0] inten, logic [15:0] frac,
			logic signed [15:0] spec, logic last);
		region_result_t r;
		cls_t           c;
		r = '0;
		c = CLS_NORMAL;
		if (inten < class_limits.shadow_int)
			c = CLS_DARK;
		else if (frac > class_limits.block_frac &&
				$signed(spec) < $signed(class_limits.block_spec))
			c = CLS_BLOCKAGE;
		else if ($signed(spec) < $signed(class_limits.lowvis_spec) &&
				inten < class_limits.highlight_int)
			c = CLS_LOWVIS;
		else if (inten > class_limits.highlight_int)
			c = CLS_BACKLIGHT;
		if (tallies[c] < TALLY_CAP)
			tallies[c] = tallies[c] + 1'b1;
		r.cls = c;
		if (last) begin
			r.done          = 1'b1;
			r.normal_n      = tallies[CLS_NORMAL];
			r.dark_n        = tallies[CLS_DARK];
			r.blockage_n    = tallies[CLS_BLOCKAGE];
			r.low_vis_n     = tallies[CLS_LOWVIS];
			r.backlight_n   = tallies[CLS_BACKLIGHT];
			r.blockage_lvl  = grade(tallies[CLS_BLOCKAGE], error_limits[15:0],
					warn_limits[15:0]);
			r.highlight_lvl = grade(tallies[CLS_BACKLIGHT], error_limits[31:16],
					warn_limits[31:16]);
			r.shadow_lvl    = grade(tallies[CLS_DARK], error_limits[47:32],
					warn_limits[47:32]);
			r.low_vis_lvl   = grade(tallies[CLS_LOWVIS], error_limits[63:48],
					warn_limits[63:48]);
			r.overall_lvl   = worse(worse(r.blockage_lvl, r.highlight_lvl),
					worse(r.shadow_lvl, r.low_vis_lvl));
			foreach (tallies[i])
				tallies[i] = '0;
		end
		return r;
	endfunction

	task automatic check_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		region_result_t want;
		region_result_t got;
		if (!arst_n) begin
			class_limits = '{shadow_int: 8'd0, highlight_int: 8'd255, block_frac: 16'hFFFF,
					block_spec: 16'sh8000, lowvis_spec: 16'sh8000};
			warn_limits  = '1;
			error_limits = '1;
			foreach (tallies[i])
				tallies[i] = '0;
			expected_results.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SHADOW_INT:    class_limits.shadow_int    = cfg_data[7:0];
					REG_HIGHLIGHT_INT: class_limits.highlight_int = cfg_data[7:0];
					REG_BLOCK_FRAC:    class_limits.block_frac    = cfg_data[15:0];
					REG_BLOCK_SPEC:    class_limits.block_spec    = cfg_data[15:0];
					REG_LOWVIS_SPEC:   class_limits.lowvis_spec   = cfg_data[15:0];
					REG_WARN_LIMITS:   warn_limits                = cfg_data;
					REG_ERROR_LIMITS:  error_limits               = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got.cls           = cls_t'(region_class);
				got.done          = frame_done;
				got.normal_n      = normal_count;
				got.dark_n        = dark_count;
				got.blockage_n    = blockage_count;
				got.low_vis_n     = low_vis_count;
				got.backlight_n   = backlight_count;
				got.blockage_lvl  = level_t'(blockage_level);
				got.highlight_lvl = level_t'(highlight_level);
				got.shadow_lvl    = level_t'(shadow_level);
				got.low_vis_lvl   = level_t'(low_vis_level);
				got.overall_lvl   = level_t'(overall_level);
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with none expected, expected nothing, actual class %0d",
							$time, region_class);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("region_class", want.cls, got.cls);
					check_field("frame_done", want.done, got.done);
					check_field("normal_count", want.normal_n, got.normal_n);
					check_field("dark_count", want.dark_n, got.dark_n);
					check_field("blockage_count", want.blockage_n, got.blockage_n);
					check_field("low_vis_count", want.low_vis_n, got.low_vis_n);
					check_field("backlight_count", want.backlight_n, got.backlight_n);
					check_field("blockage_level", want.blockage_lvl, got.blockage_lvl);
					check_field("highlight_level", want.highlight_lvl, got.highlight_lvl);
					check_field("shadow_level", want.shadow_lvl, got.shadow_lvl);
					check_field("low_vis_level", want.low_vis_lvl, got.low_vis_lvl);
					check_field("overall_level", want.overall_lvl, got.overall_lvl);
				end
			end
			// append the prediction at the tail of the queue
			if (in_valid && !in_stall)
				expected_results.insert(expected_results.size(),
						classify_region(mean_intensity, dark_fraction,
						spectrum_mean, last_region));
			pending = expected_results.size();
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the region quality tally
// Drives region beats, limit writes and result back-pressure; the checker
// beside the block predicts and compares. A directed part walks the class
// boundaries, priorities, zero limits and reset limits; a saturating frame
// pushes one tally past the region cap; random frames, before and after it,
// run under random limits with the sender and receiver idling in turn.
// ----------------------------------------------------------------------------
module tb;
	import irqt_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] UNUSED_REG_INDEX = 3'd7;
	localparam int                     LONG_HOLD_CYCLES = 64;
	localparam int                     PHASE_REGIONS    = 310;

	logic                   clk;
	logic                   arst_n          = 1'b0;
	logic                   in_valid        = 1'b0;
	logic                   in_stall;
	logic [7:0]             mean_intensity  = '0;
	logic [15:0]            dark_fraction   = '0;
	logic signed [15:0]     spectrum_mean   = '0;
	logic                   last_region     = 1'b0;
	logic                   out_valid;
	logic                   out_stall       = 1'b0;
	logic [CLASS_W-1:0]     region_class;
	logic                   frame_done;
	logic [TALLY_W-1:0]     normal_count;
	logic [TALLY_W-1:0]     dark_count;
	logic [TALLY_W-1:0]     blockage_count;
	logic [TALLY_W-1:0]     low_vis_count;
	logic [TALLY_W-1:0]     backlight_count;
	logic [LEVEL_W-1:0]     blockage_level;
	logic [LEVEL_W-1:0]     highlight_level;
	logic [LEVEL_W-1:0]     shadow_level;
	logic [LEVEL_W-1:0]     low_vis_level;
	logic [LEVEL_W-1:0]     overall_level;
	logic                   cfg_valid       = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index       = '0;
	logic [CFG_DATA_W-1:0]  cfg_data        = '0;

	int mismatches;
	int pending;

	// Pacing knobs, shared with the receiver process.
	int send_gap_pct = 0;
	int stall_pct    = 0;
	bit hold_req     = 1'b0;
	int hold_left    = 0;

	// Current limits, kept only to aim random features at the thresholds.
	int cur_shadow      = 0;
	int cur_highlight   = 255;
	int cur_block_frac  = 65535;
	int cur_block_spec  = -32768;
	int cur_lowvis_spec = -32768;

	image_region_quality_tally i_dut (.*);

	irqt_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("** image_region_quality_tally: FAILED **");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off per request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD_CYCLES;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic send_region(input logic [7:0] inten, input logic [15:0] frac,
			input logic [15:0] spec, input logic last);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		mean_intensity <= inten;
		dark_fraction  <= frac;
		spectrum_mean  <= spec;
		last_region    <= last;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold the sender until every owed result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SHADOW_INT:    cur_shadow      = data[7:0];
			REG_HIGHLIGHT_INT: cur_highlight   = data[7:0];
			REG_BLOCK_FRAC:    cur_block_frac  = data[15:0];
			REG_BLOCK_SPEC:    cur_block_spec  = $signed(data[15:0]);
			REG_LOWVIS_SPEC:   cur_lowvis_spec = $signed(data[15:0]);
			default: ;
		endcase
	endtask

	task automatic write_all_limits(input logic [7:0] shadow, input logic [7:0] highlight,
			input logic [15:0] bfrac, input logic [15:0] bspec, input logic [15:0] lvspec,
			input logic [63:0] warn, input logic [63:0] err);
		logic [63:0] junk;
		// Upper bits of the narrow registers carry noise; only the low bits count.
		junk = {$urandom, $urandom};
		write_reg(REG_SHADOW_INT, {junk[63:8], shadow});
		write_reg(REG_HIGHLIGHT_INT, {junk[55:0], highlight});
		write_reg(REG_BLOCK_FRAC, {junk[47:0], bfrac});
		write_reg(REG_BLOCK_SPEC, {junk[63:16], bspec});
		write_reg(REG_LOWVIS_SPEC, {junk[47:0], lvspec});
		write_reg(REG_WARN_LIMITS, warn);
		write_reg(REG_ERROR_LIMITS, err);
		if ($urandom_range(0, 3) == 0)
			write_reg(UNUSED_REG_INDEX, junk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_count_limit();
		case ($urandom_range(0, 6))
			0: return 16'd0;
			1: return 16'($urandom_range(1, 4));
			2: return 16'($urandom_range(0, 12));
			3: return 16'($urandom_range(0, 40));
			4: return 16'hFFFF;
			5: return 16'($urandom_range(255, 257));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int near_value(int center, int lo, int hi);
		int v;
		v = center + int'($urandom_range(0, 2)) - 1;
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [15:0] pick_spec_limit();
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($urandom_range(0, 1024) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic load_random_limits();
		logic [7:0]  shadow;
		logic [7:0]  highlight;
		logic [15:0] bfrac;
		logic [63:0] warn;
		logic [63:0] err;
		case ($urandom_range(0, 3))
			0: shadow = 8'd0;
			1: shadow = 8'd255;
			2: shadow = 8'($urandom);
			default: shadow = 8'($urandom_range(0, 100));
		endcase
		case ($urandom_range(0, 3))
			0: highlight = 8'd0;
			1: highlight = 8'd255;
			2: highlight = 8'($urandom);
			default: highlight = 8'($urandom_range(100, 255));
		endcase
		case ($urandom_range(0, 3))
			0: bfrac = 16'd0;
			1: bfrac = 16'hFFFF;
			default: bfrac = 16'($urandom);
		endcase
		for (int s = 0; s < 4; s++) begin
			warn[16*s +: 16] = pick_count_limit();
			err[16*s +: 16]  = pick_count_limit();
		end
		write_all_limits(shadow, highlight, bfrac, pick_spec_limit(), pick_spec_limit(),
				warn, err);
	endtask

	// Aim most features near the current thresholds so every class shows up.
	task automatic send_random_region(input logic last);
		int inten;
		int frac;
		int spec;
		case ($urandom_range(0, 4))
			0: inten = near_value(cur_shadow, 0, 255);
			1: inten = near_value(cur_highlight, 0, 255);
			2: inten = $urandom_range(0, 1) ? 255 : 0;
			default: inten = $urandom_range(0, 255);
		endcase
		case ($urandom_range(0, 3))
			0: frac = near_value(cur_block_frac, 0, 65535);
			1: frac = $urandom_range(0, 1) ? 65535 : 0;
			2: frac = $urandom_range(cur_block_frac, 65535);
			default: frac = $urandom_range(0, 65535);
		endcase
		case ($urandom_range(0, 5))
			0: spec = near_value(cur_block_spec, -32768, 32767);
			1: spec = near_value(cur_lowvis_spec, -32768, 32767);
			2: spec = $urandom_range(0, 1) ? 32767 : -32768;
			3: spec = int'($urandom_range(0, cur_lowvis_spec + 32768)) - 32768;
			4: spec = int'($urandom_range(0, cur_block_spec + 32768)) - 32768;
			default: spec = int'($urandom_range(0, 65535)) - 32768;
		endcase
		send_region(8'(inten), 16'(frac), 16'(spec), last);
	endtask

	task automatic run_random_frames(input int n_regions);
		int sent;
		int flen;
		bit paused;
		sent   = 0;
		paused = 1'b0;
		hold_req = 1'b1;
		while (sent < n_regions) begin
			case ($urandom_range(0, 9))
				7, 8: flen = $urandom_range(13, 40);
				9: flen = 1;
				default: flen = $urandom_range(1, 12);
			endcase
			for (int k = 0; k < flen; k++) begin
				// Halfway: stop, let everything drain, then reload limits mid-frame.
				if (!paused && sent >= n_regions / 2) begin
					paused = 1'b1;
					drain();
					load_random_limits();
				end
				send_random_region(k == flen - 1);
				sent++;
			end
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits: nothing can leave the normal class.
		send_region(8'd0, 16'd0, 16'sh8000, 1'b0);
		send_region(8'd255, 16'hFFFF, 16'sh7FFF, 1'b1);
		drain();

		// Class boundaries and priorities; low visibility warn above error.
		write_all_limits(8'd50, 8'd200, 16'h8000, 16'h0000, 16'h0100,
				64'h0001_0001_0001_0001, 64'h0000_0002_0002_0003);
		write_reg(UNUSED_REG_INDEX, '1);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_region(8'd0, 16'd0, 16'h0000, 1'b0);
		send_region(8'd49, 16'hFFFF, 16'sh8000, 1'b0);
		send_region(8'd50, 16'h8001, 16'hFFFF, 1'b0);
		send_region(8'd50, 16'h8000, 16'hFFFF, 1'b0);
		send_region(8'd100, 16'hFFFF, 16'h0000, 1'b0);
		send_region(8'd100, 16'd0, 16'h0100, 1'b0);
		send_region(8'd200, 16'd0, 16'sh8000, 1'b0);
		send_region(8'd201, 16'hFFFF, 16'sh7FFF, 1'b0);
		send_region(8'd255, 16'd0, 16'h0000, 1'b0);
		send_region(8'd199, 16'd0, 16'h00FF, 1'b1);
		drain();

		// Zero count limits and extreme intensity and spectrum limits.
		write_all_limits(8'd255, 8'd0, 16'd0, 16'sh7FFF, 16'sh7FFF, 64'd0, 64'd0);
		send_region(8'd254, 16'd1, 16'sh7FFE, 1'b0);
		send_region(8'd255, 16'd1, 16'sh7FFE, 1'b0);
		send_region(8'd255, 16'd0, 16'sh7FFE, 1'b0);
		send_region(8'd255, 16'd0, 16'sh7FFF, 1'b1);
		send_region(8'd0, 16'hFFFF, 16'sh8000, 1'b1);
		drain();

		send_gap_pct = 14;
		stall_pct    = 55;
		load_random_limits();
		run_random_frames(PHASE_REGIONS);

		send_gap_pct = 55;
		stall_pct    = 14;
		load_random_limits();
		run_random_frames(PHASE_REGIONS);

		// One long frame at full rate: the dark tally runs into the region cap.
		send_gap_pct = 0;
		stall_pct    = 0;
		write_all_limits(8'd255, 8'd255, 16'hFFFF, 16'sh8000, 16'sh8000,
				64'h0100_0100_0100_0100, 64'hFFFF_00FF_FFFF_FFFF);
		for (int k = 0; k < 300; k++)
			send_region(($urandom_range(0, 19) == 0) ? 8'd255 : 8'($urandom_range(0, 254)),
					16'($urandom), 16'($urandom), k == 299);
		drain();

		load_random_limits();
		run_random_frames(PHASE_REGIONS);

		if (mismatches == 0)
			$display("** image_region_quality_tally: PASSED **");
		else
			$display("** image_region_quality_tally: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/irqt_pkg.sv
hw/rtl/irqt_front.sv
hw/rtl/irqt_queue.sv
hw/rtl/irqt_back.sv
hw/rtl/image_region_quality_tally.sv
tb/sv/irqt_checker.sv
tb/sv/tb.sv
